// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the multichannel IIR position filter.
// Standalone header with no dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define MIPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that also holds across reset.
`define MIPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/mipf_pkg.sv =====
// Package of the multichannel IIR position filter: item and coefficient types,
// register indexes, widths and reset values. No dependencies.
`default_nettype none

package mipf_pkg;

   localparam int MIPF_CHANNELS = 8;
   localparam int TAPS          = 3;
   localparam int POS_W         = 32;
   localparam int COEF_W        = 18;
   localparam int RATE_W        = 16;
   localparam int CHAN_W        = 3;
   localparam int PROD_W        = POS_W + COEF_W;
   localparam int ACC_W         = PROD_W + 3;
   localparam int SAT_W         = ACC_W + 1;
   localparam int FRAC_W        = 16;
   localparam int STEPS         = 2 * TAPS + 1;
   localparam int STEP_W        = $clog2(STEPS);
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic signed [SAT_W-1:0] SAT_MAX  = 54'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_MIN  = -54'sd2147483648;
   localparam logic signed [SAT_W-1:0] RND_HALF = 54'sd32768;

   localparam logic [COEF_W-1:0] B0_RESET = 18'sd1877;
   localparam logic [COEF_W-1:0] B1_RESET = 18'sd5630;
   localparam logic [COEF_W-1:0] B2_RESET = 18'sd5630;
   localparam logic [COEF_W-1:0] B3_RESET = 18'sd1877;
   localparam logic [COEF_W-1:0] A1_RESET = 18'sd99543;
   localparam logic [COEF_W-1:0] A2_RESET = -18'sd62915;
   localparam logic [COEF_W-1:0] A3_RESET = 18'sd13894;
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd1000;

   typedef enum logic [2:0] {
      REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3, REG_RATE
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_ROUND, ST_VEL, ST_DONE
   } state_type;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] channel;
      logic [POS_W-1:0]  position_in;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_out;
      logic [POS_W-1:0]  position_out;
      logic [POS_W-1:0]  velocity_out;
   } rsp_item_type;

   typedef struct packed {
      logic [TAPS:0][COEF_W-1:0]   b;
      logic [TAPS-1:0][COEF_W-1:0] a;
      logic [RATE_W-1:0]           rate;
   } coef_set_type;

   typedef logic [TAPS-1:0][POS_W-1:0] hist_row_type;

endpackage

`default_nettype wire

// ===== rtl/mipf_csr.sv =====
// Configuration register file of the position filter with its APB-style port.
// Depends on mipf_pkg for register indexes, reset values and the coefficient type.
`default_nettype none

module mipf_csr
   import mipf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output coef_set_type          coefs
);

   coef_set_type coefs_ff;
   csr_reg_type  reg_idx;
   logic         wr_en;

   assign pready  = 1'b1;
   assign reg_idx = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign coefs   = coefs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b    <= {B3_RESET, B2_RESET, B1_RESET, B0_RESET};
         coefs_ff.a    <= {A3_RESET, A2_RESET, A1_RESET};
         coefs_ff.rate <= RATE_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_B0:   coefs_ff.b[0]  <= pwdata[COEF_W-1:0];
            REG_B1:   coefs_ff.b[1]  <= pwdata[COEF_W-1:0];
            REG_B2:   coefs_ff.b[2]  <= pwdata[COEF_W-1:0];
            REG_B3:   coefs_ff.b[3]  <= pwdata[COEF_W-1:0];
            REG_A1:   coefs_ff.a[0]  <= pwdata[COEF_W-1:0];
            REG_A2:   coefs_ff.a[1]  <= pwdata[COEF_W-1:0];
            REG_A3:   coefs_ff.a[2]  <= pwdata[COEF_W-1:0];
            REG_RATE: coefs_ff.rate  <= pwdata[RATE_W-1:0];
            default:  coefs_ff       <= coefs_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_B0:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.b[0][COEF_W-1]}}, coefs_ff.b[0]};
         REG_B1:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.b[1][COEF_W-1]}}, coefs_ff.b[1]};
         REG_B2:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.b[2][COEF_W-1]}}, coefs_ff.b[2]};
         REG_B3:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.b[3][COEF_W-1]}}, coefs_ff.b[3]};
         REG_A1:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.a[0][COEF_W-1]}}, coefs_ff.a[0]};
         REG_A2:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.a[1][COEF_W-1]}}, coefs_ff.a[1]};
         REG_A3:   prdata = {{(CSR_DATA_W-COEF_W){coefs_ff.a[2][COEF_W-1]}}, coefs_ff.a[2]};
         REG_RATE: prdata = {{(CSR_DATA_W-RATE_W){1'b0}}, coefs_ff.rate};
         default:  prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/multichannel_iir_position_filter_top.sv =====
// Multichannel third-order IIR position filter, top level.
// Depends on mipf_pkg, mipf_csr and assert_macros.svh.
//
// Each item on the req channel either filters one Q16.16 position sample of a
// channel or clears the history of every channel. A sample item returns one
// item on the rsp channel with the channel, the filtered position and the
// velocity; a clear item and a sample for a channel beyond CHANNELS return
// nothing. The user must write coefficients and the sample rate through the
// APB-style port only while the block is idle; the block does not enforce it.
// The history memory is read at the edge that accepts a sample, then the
// taps go one after another through the single 32x18 multiplier, then come
// the last add, rounding, the velocity multiply and the write-back. One item
// is in work at a time: the block takes no new item until the last one is
// finished and it is back in the idle state.
// A clear or dropped item does not leave the idle state.
// The result register holds a finished item while the receiver stalls, and the
// next item is accepted and worked meanwhile; it waits in its final state until
// the result register is free. Reset clears the channel state at once and needs
// no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module multichannel_iir_position_filter_top
   import mipf_pkg::*;
#(
   parameter int CHANNELS = MIPF_CHANNELS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   coef_set_type coefs;

   state_type   state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CHANNELS-1:0] primed_ff, primed_in;
   logic [CHANNELS-1:0] velrdy_ff, velrdy_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [CHAN_W-1:0]       chan_ff;
   logic signed [POS_W-1:0] x_ff;
   logic                    primed_cur_ff;
   logic                    velrdy_cur_ff;
   hist_row_type            xrow_ff, yrow_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [POS_W-1:0]  y_ff;
   logic signed [PROD_W-1:0] vel_prod_ff;
   rsp_item_type            rsp_data_ff;

   hist_row_type xmem [CHANNELS];
   hist_row_type ymem [CHANNELS];

   logic          accept, clear_acc, sample_acc, chan_ok, out_free;
   logic          mul_en, sum_en, rnd_en, vel_en, wr_en;
   logic [AW-1:0] rd_addr, cur_addr;
   hist_row_type  xh, yh;
   logic [1:0]    tap_idx;
   logic signed [POS_W-1:0]  opnd_x;
   logic signed [COEF_W-1:0] opnd_c;
   logic signed [PROD_W-1:0] prod_in, vel_prod_in;
   logic signed [SAT_W-1:0]  rnd_sum, rnd_val;
   logic signed [POS_W:0]    diff;
   logic signed [RATE_W:0]   rate_s;

   function automatic logic [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      if (v > SAT_MAX) begin
         return SAT_MAX[POS_W-1:0];
      end else if (v < SAT_MIN) begin
         return SAT_MIN[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

   mipf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coefs   (coefs)
   );

   assign accept     = req_valid && req_ready;
   assign chan_ok    = 32'(req_data.channel) < CHANNELS;
   assign clear_acc  = accept && (req_data.op == OP_CLEAR);
   assign sample_acc = accept && (req_data.op == OP_SAMPLE) && chan_ok;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rd_addr    = AW'(req_data.channel);
   assign cur_addr   = AW'(chan_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (sample_acc) state_in = ST_MUL;
         ST_MUL:   if (step_ff == STEP_W'(STEPS - 1)) state_in = ST_SUM;
         ST_SUM:   state_in = ST_ROUND;
         ST_ROUND: state_in = ST_VEL;
         ST_VEL:   state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_en    = 1'b0;
      sum_en    = 1'b0;
      rnd_en    = 1'b0;
      vel_en    = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_MUL:   mul_en    = 1'b1;
         ST_SUM:   sum_en    = 1'b1;
         ST_ROUND: rnd_en    = 1'b1;
         ST_VEL:   vel_en    = 1'b1;
         ST_DONE:  wr_en     = out_free;
         default:  req_ready = 1'b0;
      endcase
   end

   always_comb begin
      step_in = '0;
      if (mul_en && (step_ff != STEP_W'(STEPS - 1))) begin
         step_in = step_ff + 1'b1;
      end
      primed_in = primed_ff;
      velrdy_in = velrdy_ff;
      if (clear_acc) begin
         primed_in = '0;
      end else if (wr_en) begin
         primed_in[cur_addr] = 1'b1;
         velrdy_in[cur_addr] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         primed_ff    <= '0;
         velrdy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         primed_ff    <= primed_in;
         velrdy_ff    <= velrdy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         xrow_ff <= xmem[rd_addr];
      end
      if (wr_en) begin
         xmem[cur_addr] <= {xh[1], xh[0], x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         yrow_ff <= ymem[rd_addr];
      end
      if (wr_en) begin
         ymem[cur_addr] <= {yh[1], yh[0], y_ff};
      end
   end

   assign xh = primed_cur_ff ? xrow_ff : {TAPS{x_ff}};
   assign yh = primed_cur_ff ? yrow_ff : {TAPS{x_ff}};

   always_comb begin
      tap_idx = 2'((step_ff - 1'b1) >> 1);
      if (step_ff == '0) begin
         opnd_x = x_ff;
         opnd_c = coefs.b[0];
      end else if (step_ff[0]) begin
         opnd_x = xh[tap_idx];
         opnd_c = coefs.b[tap_idx + 1'b1];
      end else begin
         opnd_x = yh[tap_idx];
         opnd_c = coefs.a[tap_idx];
      end
   end

   assign prod_in     = opnd_x * opnd_c;
   assign rnd_sum     = SAT_W'(acc_ff) + RND_HALF;
   assign rnd_val     = rnd_sum >>> FRAC_W;
   assign diff        = (POS_W + 1)'(y_ff) - (POS_W + 1)'($signed(yh[0]));
   assign rate_s      = $signed({1'b0, coefs.rate});
   assign vel_prod_in = diff * rate_s;

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         chan_ff       <= req_data.channel;
         x_ff          <= req_data.position_in;
         primed_cur_ff <= primed_ff[rd_addr];
         velrdy_cur_ff <= velrdy_ff[rd_addr];
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (mul_en && (step_ff == '0)) begin
         acc_ff <= '0;
      end else if (mul_en || sum_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (rnd_en) begin
         y_ff <= sat32(rnd_val);
      end
      if (vel_en) begin
         vel_prod_ff <= vel_prod_in;
      end
      if (wr_en) begin
         rsp_data_ff.channel_out  <= chan_ff;
         rsp_data_ff.position_out <= y_ff;
         rsp_data_ff.velocity_out <= velrdy_cur_ff ? sat32(SAT_W'(vel_prod_ff)) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MIPF_ASSERT(a_clear_unprimes, clock, reset, clear_acc |=> (primed_ff == '0), "clear item left a channel primed")
   `MIPF_ASSERT(a_write_gives_item, clock, reset, wr_en |=> rsp_valid_ff, "history write without a result item")
   `MIPF_ASSERT(a_stall_holds_done, clock, reset, (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE), "finished item left its final state while the result was stalled")
   `MIPF_ASSERT(a_step_bounded, clock, reset, mul_en |-> (step_ff < STEP_W'(STEPS)), "tap step out of range")
   `MIPF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid_ff && state_ff == ST_IDLE && primed_ff == '0), "reset did not clear control state")

endmodule

`default_nettype wire
